// ----- hdl/rrpe_pkg.sv -----
// Shared types, constants and small helper functions for the retro pixel effects block.
// No dependencies; the other files that use it refer to this package by scoped names.
package rrpe_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TINT_COLOR        = 3'd0,
    REG_TINT_PERCENT      = 3'd1,
    REG_DOT_MATRIX_ENABLE = 3'd2,
    REG_DOT_GRID_SIZE     = 3'd3,
    REG_SCANLINE_ENABLE   = 3'd4,
    REG_SCANLINE_PERCENT  = 3'd5,
    REG_PANEL_ROTATED     = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    TINT_NONE    = 3'd0,
    TINT_GREEN   = 3'd1,
    TINT_AMBER   = 3'd2,
    TINT_BLUE    = 3'd3,
    TINT_MAGENTA = 3'd4
  } tint_color_e;

  typedef struct packed {
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
  } rgb_t;

  // Decoded configuration as seen by the datapath.
  typedef struct packed {
    logic       tint_on;
    logic [8:0] tint_k;
    logic [8:0] tint_ki;
    rgb_t       accent;
    logic       dot_on;
    logic [5:0] grid;
    logic       scan_on;
    logic [8:0] scan_ki;
    logic       rotated;
  } cfg_t;

  // Per-pixel position decisions that travel beside the color data.
  typedef struct packed {
    logic off_dot;
    logic scan_hit;
  } pos_flags_t;

  localparam logic [12:0] LUMA_R_W = 13'd76;
  localparam logic [12:0] LUMA_G_W = 13'd150;
  localparam logic [12:0] LUMA_B_W = 13'd29;
  localparam logic [8:0]  Q8_ONE   = 9'd256;
  localparam logic [6:0]  PCT_MAX  = 7'd100;
  // 5243 / 2^19 approximates 1/100 closely enough that p*256/100 is exact for p <= 100.
  localparam logic [19:0] PCT_RECIP = 20'd5243;

  localparam rgb_t ACCENT_BLACK   = '{r: 5'd0,  g: 6'd0,  b: 5'd0};
  localparam rgb_t ACCENT_GREEN   = '{r: 5'd6,  g: 6'd63, b: 5'd12};
  localparam rgb_t ACCENT_AMBER   = '{r: 5'd31, g: 6'd44, b: 5'd4};
  localparam rgb_t ACCENT_BLUE    = '{r: 5'd6,  g: 6'd32, b: 5'd31};
  localparam rgb_t ACCENT_MAGENTA = '{r: 5'd31, g: 6'd16, b: 5'd28};

  // Percent (clamped to 100) to Q8 strength.
  function automatic logic [8:0] q8_of_pct(logic [6:0] pct);
    logic [6:0]  pc;
    logic [19:0] prod;
    pc   = (pct > PCT_MAX) ? PCT_MAX : pct;
    prod = 20'(pc) * PCT_RECIP;
    return prod[19:11];
  endfunction

  function automatic rgb_t accent_of(logic [2:0] color);
    rgb_t ac;
    unique case (tint_color_e'(color))
      TINT_GREEN:   ac = ACCENT_GREEN;
      TINT_AMBER:   ac = ACCENT_AMBER;
      TINT_BLUE:    ac = ACCENT_BLUE;
      TINT_MAGENTA: ac = ACCENT_MAGENTA;
      default:      ac = ACCENT_BLACK;
    endcase
    return ac;
  endfunction

  // Floor division by 255, exact for the small products used here.
  function automatic logic [2:0] div255(logic [10:0] v);
    logic [10:0] t;
    t = v + 11'(v[10:8]) + 11'd1;
    return t[10:8];
  endfunction

endpackage

// ----- hdl/rrpe_ifs.sv -----
// Valid/ready channel interfaces for pixel input, pixel output and configuration writes.
// Depends on rrpe_pkg for the configuration field widths.
interface rrpe_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_in;
  logic [7:0]  native_x;
  logic [8:0]  native_y;

  modport source (output valid, output pixel_in, output native_x, output native_y,
                  input ready);
  modport sink   (input valid, input pixel_in, input native_x, input native_y,
                  output ready);
endinterface

interface rrpe_pix_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

interface rrpe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rrpe_pkg::CFG_IDX_W-1:0]   index;
  logic [rrpe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rrpe_cfg_regs.sv -----
// Configuration register file and its decode into the datapath control struct.
// Depends on rrpe_pkg (register indexes, cfg_t, percent conversion, accent table).
module rrpe_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_valid_i,
  input  logic [rrpe_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [rrpe_pkg::CFG_DATA_W-1:0] wr_data_i,
  output logic                            wr_ready_o,
  output rrpe_pkg::cfg_t                  cfg_o
);

  logic [2:0] tint_color_q;
  logic [6:0] tint_pct_q;
  logic [8:0] tint_k_q;
  logic       dot_en_q;
  logic [5:0] grid_q;
  logic       scan_en_q;
  logic [6:0] scan_pct_q;
  logic [8:0] scan_k_q;
  logic       rotated_q;

  assign wr_ready_o = 1'b1;

  // The Q8 strengths are converted once per write so the pixel path sees a ready value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_color_q <= 3'd0;
      tint_pct_q   <= 7'd0;
      tint_k_q     <= 9'd0;
      dot_en_q     <= 1'b0;
      grid_q       <= 6'd2;
      scan_en_q    <= 1'b0;
      scan_pct_q   <= 7'd0;
      scan_k_q     <= 9'd0;
      rotated_q    <= 1'b1;
    end else if (wr_valid_i) begin
      unique case (rrpe_pkg::reg_idx_e'(wr_index_i))
        rrpe_pkg::REG_TINT_COLOR:        tint_color_q <= wr_data_i[2:0];
        rrpe_pkg::REG_TINT_PERCENT: begin
          tint_pct_q <= wr_data_i;
          tint_k_q   <= rrpe_pkg::q8_of_pct(wr_data_i);
        end
        rrpe_pkg::REG_DOT_MATRIX_ENABLE: dot_en_q     <= wr_data_i[0];
        rrpe_pkg::REG_DOT_GRID_SIZE:     grid_q       <= wr_data_i[5:0];
        rrpe_pkg::REG_SCANLINE_ENABLE:   scan_en_q    <= wr_data_i[0];
        rrpe_pkg::REG_SCANLINE_PERCENT: begin
          scan_pct_q <= wr_data_i;
          scan_k_q   <= rrpe_pkg::q8_of_pct(wr_data_i);
        end
        rrpe_pkg::REG_PANEL_ROTATED:     rotated_q    <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.tint_on = (tint_color_q != 3'd0) && (tint_pct_q != 7'd0);
    cfg_o.tint_k  = tint_k_q;
    cfg_o.tint_ki = rrpe_pkg::Q8_ONE - tint_k_q;
    cfg_o.accent  = rrpe_pkg::accent_of(tint_color_q);
    cfg_o.dot_on  = dot_en_q;
    // A grid size of zero behaves as one.
    cfg_o.grid    = (grid_q == 6'd0) ? 6'd1 : grid_q;
    cfg_o.scan_on = scan_en_q && (scan_pct_q != 7'd0);
    cfg_o.scan_ki = rrpe_pkg::Q8_ONE - scan_k_q;
    cfg_o.rotated = rotated_q;
  end

endmodule

// ----- hdl/rrpe_pos_flags.sv -----
// Position path: logical coordinate mapping, pipelined grid remainder test and scanline parity.
// Depends on rrpe_pkg (cfg_t, pos_flags_t); spans pipeline stages one to four.
module rrpe_pos_flags #(
  parameter int unsigned PANEL_WIDTH  = 172,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic                   clk_i,
  input  logic [3:0]             stage_en_i,
  input  logic [7:0]             native_x_i,
  input  logic [8:0]             native_y_i,
  input  rrpe_pkg::cfg_t         cfg_i,
  output rrpe_pkg::pos_flags_t   flags_o
);

  localparam int CW_A = ($clog2(PANEL_WIDTH) > 9) ? $clog2(PANEL_WIDTH) : 9;
  localparam int CW   = ($clog2(PANEL_HEIGHT) > CW_A) ? $clog2(PANEL_HEIGHT) : CW_A;
  localparam int H1   = CW / 2;
  localparam logic signed [CW:0] PW_M1 = (CW+1)'(PANEL_WIDTH - 1);
  localparam logic signed [CW:0] PH_M1 = (CW+1)'(PANEL_HEIGHT - 1);

  // One restoring step of the remainder by the grid pitch.
  function automatic logic [5:0] rem_step(logic [5:0] rem, logic bit_in, logic [5:0] grid);
    logic [6:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, grid}) begin
      t = t - {1'b0, grid};
    end
    return t[5:0];
  endfunction

  logic signed [CW:0] xs, ys, lx, ly;
  logic [CW-1:0]      mag_x, mag_y;
  logic [5:0]         rem_x1, rem_y1, rem_x2, rem_y2;
  logic               scan_hit1;

  logic [CW-1:0]        mag_x_q, mag_y_q;
  logic [5:0]           rem_x_q, rem_y_q;
  logic                 scan_hit_q;
  rrpe_pkg::pos_flags_t flags2_q, flags3_q, flags4_q;

  // Stage 1: map to logical space, take magnitudes, run the upper remainder steps.
  always_comb begin
    xs = $signed({{(CW+1-8){1'b0}}, native_x_i});
    ys = $signed({{(CW+1-9){1'b0}}, native_y_i});
    ly = cfg_i.rotated ? (PW_M1 - xs) : xs;
    lx = cfg_i.rotated ? ys : (PH_M1 - ys);
    mag_x = lx[CW] ? CW'(-lx) : lx[CW-1:0];
    mag_y = ly[CW] ? CW'(-ly) : ly[CW-1:0];
    rem_x1 = 6'd0;
    rem_y1 = 6'd0;
    for (int i = CW - 1; i >= CW - H1; i--) begin
      rem_x1 = rem_step(rem_x1, mag_x[i], cfg_i.grid);
      rem_y1 = rem_step(rem_y1, mag_y[i], cfg_i.grid);
    end
    scan_hit1 = cfg_i.scan_on && (native_x_i[0] == cfg_i.rotated);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      mag_x_q    <= mag_x;
      mag_y_q    <= mag_y;
      rem_x_q    <= rem_x1;
      rem_y_q    <= rem_y1;
      scan_hit_q <= scan_hit1;
    end
  end

  // Stage 2: lower remainder steps and the on-dot decision.
  always_comb begin
    rem_x2 = rem_x_q;
    rem_y2 = rem_y_q;
    for (int i = CW - H1 - 1; i >= 0; i--) begin
      rem_x2 = rem_step(rem_x2, mag_x_q[i], cfg_i.grid);
      rem_y2 = rem_step(rem_y2, mag_y_q[i], cfg_i.grid);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      flags2_q.off_dot  <= cfg_i.dot_on && !((rem_x2 == 6'd0) && (rem_y2 == 6'd0));
      flags2_q.scan_hit <= scan_hit_q;
    end
    if (stage_en_i[2]) begin
      flags3_q <= flags2_q;
    end
    if (stage_en_i[3]) begin
      flags4_q <= flags3_q;
    end
  end

  assign flags_o = flags4_q;

endmodule

// ----- hdl/rrpe_tint.sv -----
// Color path for stages one to four: unswap, luma, gray level, accent mix and final tint blend.
// Depends on rrpe_pkg (rgb_t, cfg_t, luma weights, div255).
module rrpe_tint (
  input  logic            clk_i,
  input  logic [3:0]      stage_en_i,
  input  logic [15:0]     pixel_in_i,
  input  rrpe_pkg::cfg_t  cfg_i,
  output rrpe_pkg::rgb_t  rgb_o
);

  rrpe_pkg::rgb_t rgb_in;
  logic [12:0]    luma_sum;

  rrpe_pkg::rgb_t rgb1_q, rgb2_q, rgb3_q, rgb4_q;
  logic [4:0]     luma1_q;

  logic [2:0]     lr_full, lg_full;
  logic [13:0]    ke_prod;
  logic [1:0]     lr2_q;
  logic [2:0]     lg2_q;
  logic [4:0]     ke2_q;

  logic [8:0]     kei;
  logic [12:0]    mr_sum, mb_sum;
  logic [13:0]    mg_sum;
  rrpe_pkg::rgb_t mix3_q;

  logic [13:0]    tr_sum, tb_sum;
  logic [14:0]    tg_sum;
  rrpe_pkg::rgb_t tinted;

  // Stage 1: byte swap back to RGB565 and the weighted luma.
  always_comb begin
    rgb_in   = rrpe_pkg::rgb_t'({pixel_in_i[7:0], pixel_in_i[15:8]});
    luma_sum = 13'(rgb_in.r) * rrpe_pkg::LUMA_R_W
             + 13'(rgb_in.g[5:1]) * rrpe_pkg::LUMA_G_W
             + 13'(rgb_in.b) * rrpe_pkg::LUMA_B_W;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      rgb1_q  <= rgb_in;
      luma1_q <= luma_sum[12:8];
    end
  end

  // Stage 2: gray levels and the luma-scaled accent strength.
  always_comb begin
    lr_full = rrpe_pkg::div255(11'(luma1_q) * 11'd31);
    lg_full = rrpe_pkg::div255(11'(luma1_q) * 11'd63);
    ke_prod = 14'(cfg_i.tint_k) * 14'(luma1_q);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      rgb2_q <= rgb1_q;
      lr2_q  <= lr_full[1:0];
      lg2_q  <= lg_full;
      ke2_q  <= ke_prod[12:8];
    end
  end

  // Stage 3: blend gray toward the accent color.
  always_comb begin
    kei    = rrpe_pkg::Q8_ONE - 9'(ke2_q);
    mr_sum = 13'(lr2_q) * 13'(kei) + 13'(cfg_i.accent.r) * 13'(ke2_q);
    mg_sum = 14'(lg2_q) * 14'(kei) + 14'(cfg_i.accent.g) * 14'(ke2_q);
    mb_sum = 13'(lr2_q) * 13'(kei) + 13'(cfg_i.accent.b) * 13'(ke2_q);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      rgb3_q   <= rgb2_q;
      mix3_q.r <= mr_sum[12:8];
      mix3_q.g <= mg_sum[13:8];
      mix3_q.b <= mb_sum[12:8];
    end
  end

  // Stage 4: mix the accent blend back with the original and saturate.
  always_comb begin
    tr_sum = 14'(rgb3_q.r) * 14'(cfg_i.tint_ki) + 14'(mix3_q.r) * 14'(cfg_i.tint_k);
    tg_sum = 15'(rgb3_q.g) * 15'(cfg_i.tint_ki) + 15'(mix3_q.g) * 15'(cfg_i.tint_k);
    tb_sum = 14'(rgb3_q.b) * 14'(cfg_i.tint_ki) + 14'(mix3_q.b) * 14'(cfg_i.tint_k);
    tinted.r = (tr_sum[13:8] > 6'd31) ? 5'd31 : tr_sum[12:8];
    tinted.g = (tg_sum[14:8] > 7'd63) ? 6'd63 : tg_sum[13:8];
    tinted.b = (tb_sum[13:8] > 6'd31) ? 5'd31 : tb_sum[12:8];
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      rgb4_q <= cfg_i.tint_on ? tinted : rgb3_q;
    end
  end

  assign rgb_o = rgb4_q;

endmodule

// ----- hdl/rgb565_retro_pixel_effects_top.sv -----
// Top level of the retro pixel effects pipeline: stage control, dimming stage and output.
// Depends on rrpe_pkg, the channel interfaces, rrpe_cfg_regs, rrpe_tint and rrpe_pos_flags.
//
//  Channel   Dir  Payload                              Handshake
//  px_in_i   in   pixel_in[15:0] native_x[7:0] native_y[8:0]  valid/ready
//  px_out_o  out  pixel_out[15:0]                      valid/ready
//  cfg_i     in   index[2:0] data[6:0]                 valid/ready (ready always high)
//
// Five register stages; a result is offered from the last stage until the output takes it.
// Throughput is one pixel per cycle while the output is ready, bounded by the
// single-entry stages of the pipeline.
// Reset clears the stage valid bits and restores the register defaults; no clearing pass.
// Each stage holds while the one ahead is full and stalled, so a stall backs up stage by
// stage and bubbles are squeezed out before the input is held off.
module rgb565_retro_pixel_effects_top #(
  parameter int unsigned PANEL_WIDTH  = 172,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rrpe_pix_in_if.sink           px_in_i,
  rrpe_pix_out_if.source        px_out_o,
  rrpe_cfg_if.sink              cfg_i
);

  localparam int unsigned NSTG = 5;

  rrpe_pkg::cfg_t       cfg;
  rrpe_pkg::rgb_t       rgb4;
  rrpe_pkg::pos_flags_t flags4;

  logic [NSTG:1]   v_q;
  logic [NSTG+1:1] en;

  logic [6:0]     dr;
  logic [7:0]     dg;
  logic [6:0]     db;
  rrpe_pkg::rgb_t dim;
  logic [13:0]    sr, sb;
  logic [14:0]    sg;
  rrpe_pkg::rgb_t res;
  rrpe_pkg::rgb_t out_q;

  always_comb begin
    en[NSTG+1] = px_out_o.ready;
    for (int i = NSTG; i >= 1; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= px_in_i.valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign px_in_i.ready = en[1];

  rrpe_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  rrpe_tint u_tint (
    .clk_i      (clk_i),
    .stage_en_i (en[4:1]),
    .pixel_in_i (px_in_i.pixel_in),
    .cfg_i      (cfg),
    .rgb_o      (rgb4)
  );

  rrpe_pos_flags #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_pos (
    .clk_i      (clk_i),
    .stage_en_i (en[4:1]),
    .native_x_i (px_in_i.native_x),
    .native_y_i (px_in_i.native_y),
    .cfg_i      (cfg),
    .flags_o    (flags4)
  );

  // Stage 5: off-dot dimming to 3/8, then the scanline scale.
  always_comb begin
    dr = 7'(rgb4.r) * 7'd3;
    dg = 8'(rgb4.g) * 8'd3;
    db = 7'(rgb4.b) * 7'd3;
    dim = rgb4;
    if (flags4.off_dot) begin
      dim.r = 5'(dr[6:3]);
      dim.g = 6'(dg[7:3]);
      dim.b = 5'(db[6:3]);
    end
    sr = 14'(dim.r) * 14'(cfg.scan_ki);
    sg = 15'(dim.g) * 15'(cfg.scan_ki);
    sb = 14'(dim.b) * 14'(cfg.scan_ki);
    res = dim;
    if (flags4.scan_hit) begin
      res.r = sr[12:8];
      res.g = sg[13:8];
      res.b = sb[12:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG]) begin
      out_q <= res;
    end
  end

  assign px_out_o.valid     = v_q[NSTG];
  assign px_out_o.pixel_out = {out_q[7:0], out_q[15:8]};

endmodule

// ----- hdl/rrpe_chk.sv -----
// Port-level checker for the retro pixel effects top level, attached by bind.
// Depends only on the top level's ports.
module rrpe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready && rst_ni;

  // A result that is offered and not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("output changed while stalled");

  // Five stages: whatever happens downstream, an input transfer leaves the output full.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##5 out_valid)
    else $error("pixel did not reach the output stage in time");

  // A result can only appear once a pixel has been through all five stages.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 5))
    else $error("output became valid without a matching input transfer");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind rgb565_retro_pixel_effects_top rrpe_chk u_rrpe_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (px_in_i.valid),
  .in_ready  (px_in_i.ready),
  .out_valid (px_out_o.valid),
  .out_ready (px_out_o.ready),
  .out_pixel (px_out_o.pixel_out),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);

// ----- tb/rgb565_retro_pixel_effects_top_test.sv -----
// Self-checking testbench for the retro pixel effects pipeline: tint, dot matrix and scanlines.
// Depends on rrpe_pkg and the channel interfaces; predicts each output pixel from its inputs
// and the register settings, and compares the results in order of transfer.
module rgb565_retro_pixel_effects_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PANEL_W = 172;
  localparam int unsigned PANEL_H = 320;
  localparam logic [2:0] TINT_UNDEFINED = 3'd7;

  // Raw write data for each register, in register order.
  typedef struct {
    logic [6:0] tint_color, tint_pct, dot_en, grid, scan_en, scan_pct, rotated;
  } fx_settings_t;

  typedef struct {
    logic [15:0] px;
    logic [7:0]  x;
    logic [8:0]  y;
    logic [15:0] want;
  } pixel_expect_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rrpe_pix_in_if  pix_in_bus ();
  rrpe_pix_out_if pix_out_bus ();
  rrpe_cfg_if     cfg_bus ();

  // Register copies as the block holds them.
  logic [2:0] cur_tint_color;
  logic [6:0] cur_tint_pct;
  logic       cur_dot_en;
  logic [5:0] cur_grid;
  logic       cur_scan_en;
  logic [6:0] cur_scan_pct;
  logic       cur_rot;

  pixel_expect_t pending_pixels[$];
  int  mismatch_count = 0;
  int  stall_left     = 0;
  bit  in_gaps        = 1'b0;
  bit  out_gaps       = 1'b0;

  rgb565_retro_pixel_effects_top #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .px_in_i (pix_in_bus),
    .px_out_o(pix_out_bus),
    .cfg_i   (cfg_bus)
  );

  always #1 clk = ~clk;

  function automatic int unsigned pct_q8(logic [6:0] pct);
    int unsigned p;
    p = (pct > 7'd100) ? 100 : pct;
    return (p * 256) / 100;
  endfunction

  function automatic logic [15:0] pixel_effects_of(logic [15:0] px, logic [7:0] x,
                                                   logic [8:0] y);
    logic [15:0] rgb;
    logic [23:0] accent;
    int unsigned r, g, b, ar, ag, ab, k, ki, luma, lr, lg, ke, kei, mr, mg, mb, grid, ks;
    int lx, ly, mx, my;
    rgb = {px[7:0], px[15:8]};
    r = rgb[15:11];
    g = rgb[10:5];
    b = rgb[4:0];

    if (cur_tint_color != rrpe_pkg::TINT_NONE && cur_tint_pct != 0) begin
      // Accents are given at 8 bits per channel and truncated to 5/6/5.
      case (rrpe_pkg::tint_color_e'(cur_tint_color))
        rrpe_pkg::TINT_GREEN:   accent = 24'h33FF66;
        rrpe_pkg::TINT_AMBER:   accent = 24'hFFB020;
        rrpe_pkg::TINT_BLUE:    accent = 24'h3080FF;
        rrpe_pkg::TINT_MAGENTA: accent = 24'hFF40E0;
        default:                accent = 24'h000000;
      endcase
      ar = accent[23:19];
      ag = accent[15:10];
      ab = accent[7:3];
      k    = pct_q8(cur_tint_pct);
      ki   = 256 - k;
      luma = (r * 76 + (g >> 1) * 150 + b * 29) >> 8;
      lr   = (luma * 31) / 255;
      lg   = (luma * 63) / 255;
      ke   = (k * luma) >> 8;
      kei  = 256 - ke;
      mr   = (lr * kei + ar * ke) >> 8;
      mg   = (lg * kei + ag * ke) >> 8;
      mb   = (lr * kei + ab * ke) >> 8;
      r = (r * ki + mr * k) >> 8;
      g = (g * ki + mg * k) >> 8;
      b = (b * ki + mb * k) >> 8;
      if (r > 31) r = 31;
      if (g > 63) g = 63;
      if (b > 31) b = 31;
    end

    if (cur_dot_en) begin
      grid = (cur_grid == 0) ? 1 : cur_grid;
      if (cur_rot) begin
        ly = int'(PANEL_W) - 1 - int'(x);
        lx = int'(y);
      end else begin
        ly = int'(x);
        lx = int'(PANEL_H) - 1 - int'(y);
      end
      // Out-of-range positions give negative logical coordinates; the magnitude is tested.
      mx = (lx < 0) ? -lx : lx;
      my = (ly < 0) ? -ly : ly;
      if ((mx % grid) != 0 || (my % grid) != 0) begin
        r = (r * 3) >> 3;
        g = (g * 3) >> 3;
        b = (b * 3) >> 3;
      end
    end

    if (cur_scan_en && cur_scan_pct != 0 && x[0] == cur_rot) begin
      ks = 256 - pct_q8(cur_scan_pct);
      r = (r * ks) >> 8;
      g = (g * ks) >> 8;
      b = (b * ks) >> 8;
    end

    rgb = {5'(r), 6'(g), 5'(b)};
    return {rgb[7:0], rgb[15:8]};
  endfunction

  function automatic fx_settings_t make_settings(logic [6:0] color, logic [6:0] tpct,
                                                 logic [6:0] dot, logic [6:0] grid,
                                                 logic [6:0] scan, logic [6:0] spct,
                                                 logic [6:0] rot);
    fx_settings_t s;
    s.tint_color = color;
    s.tint_pct   = tpct;
    s.dot_en     = dot;
    s.grid       = grid;
    s.scan_en    = scan;
    s.scan_pct   = spct;
    s.rotated    = rot;
    return s;
  endfunction

  function automatic logic [6:0] random_pct();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd127;
      3:       return 7'($urandom_range(127, 101));
      default: return 7'($urandom_range(100, 1));
    endcase
  endfunction

  // Narrow registers sometimes get stray high bits, which the block must drop.
  function automatic logic [6:0] random_narrow(int unsigned max_legal);
    return ($urandom_range(5) == 0) ? 7'($urandom) : 7'($urandom_range(max_legal));
  endfunction

  function automatic fx_settings_t random_settings();
    fx_settings_t s;
    logic [6:0] grid;
    case ($urandom_range(7))
      0:       grid = 7'd0;
      1:       grid = 7'd1;
      2:       grid = 7'd32;
      3:       grid = 7'($urandom_range(127));
      default: grid = 7'($urandom_range(8, 2));
    endcase
    s = make_settings(random_narrow(7), random_pct(), random_narrow(1), grid,
                      random_narrow(1), random_pct(), random_narrow(1));
    return s;
  endfunction

  // Lowers the pixel valid and waits until every expected pixel has come out.
  task automatic wait_idle();
    pix_in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Writes every register back to back; the block must be idle.
  task automatic write_settings(input fx_settings_t s);
    rrpe_pkg::reg_idx_e idx;
    logic [6:0]         d;
    idx = idx.first();
    do begin
      case (idx)
        rrpe_pkg::REG_TINT_COLOR:        d = s.tint_color;
        rrpe_pkg::REG_TINT_PERCENT:      d = s.tint_pct;
        rrpe_pkg::REG_DOT_MATRIX_ENABLE: d = s.dot_en;
        rrpe_pkg::REG_DOT_GRID_SIZE:     d = s.grid;
        rrpe_pkg::REG_SCANLINE_ENABLE:   d = s.scan_en;
        rrpe_pkg::REG_SCANLINE_PERCENT:  d = s.scan_pct;
        default:                         d = s.rotated;
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= d;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      case (idx)
        rrpe_pkg::REG_TINT_COLOR:        cur_tint_color = d[2:0];
        rrpe_pkg::REG_TINT_PERCENT:      cur_tint_pct   = d;
        rrpe_pkg::REG_DOT_MATRIX_ENABLE: cur_dot_en     = d[0];
        rrpe_pkg::REG_DOT_GRID_SIZE:     cur_grid       = d[5:0];
        rrpe_pkg::REG_SCANLINE_ENABLE:   cur_scan_en    = d[0];
        rrpe_pkg::REG_SCANLINE_PERCENT:  cur_scan_pct   = d;
        default:                         cur_rot        = d[0];
      endcase
      idx = idx.next();
    end while (idx != idx.first());
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [15:0] px, input logic [7:0] x, input logic [8:0] y);
    pixel_expect_t e;
    while (in_gaps && $urandom_range(99) < 31) begin
      pix_in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.pixel_in <= px;
    pix_in_bus.native_x <= x;
    pix_in_bus.native_y <= y;
    @(posedge clk);
    while (!pix_in_bus.ready) @(posedge clk);
    e.px   = px;
    e.x    = x;
    e.y    = y;
    e.want = pixel_effects_of(px, x, y);
    pending_pixels.push_back(e);
  endtask

  // Mostly on-panel positions, with some beyond the panel edges.
  task automatic send_random_pixel();
    logic [7:0] x;
    logic [8:0] y;
    x = ($urandom_range(9) == 0) ? 8'($urandom_range(255, PANEL_W)) :
                                   8'($urandom_range(PANEL_W - 1, 0));
    y = ($urandom_range(9) == 0) ? 9'($urandom_range(511, PANEL_H)) :
                                   9'($urandom_range(PANEL_H - 1, 0));
    send_pixel(16'($urandom), x, y);
  endtask

  task automatic test_reset_defaults();
    send_pixel(16'h0000, 8'd0,   9'd0);
    send_pixel(16'hFFFF, 8'd171, 9'd319);
    send_pixel(16'h5AA5, 8'd128, 9'd256);
    send_pixel(16'hA55A, 8'd255, 9'd511);
    wait_idle();
  endtask

  task automatic test_tint();
    rrpe_pkg::tint_color_e c;
    c = rrpe_pkg::TINT_GREEN;
    do begin
      write_settings(make_settings(7'(c), 7'd50, 7'd0, 7'd2, 7'd0, 7'd0, 7'd1));
      send_pixel(16'h18C6, 8'd10, 9'd20);
      wait_idle();
      c = c.next();
    end while (c != c.first());
    write_settings(make_settings(7'(rrpe_pkg::TINT_AMBER), 7'd100, 7'd0, 7'd2, 7'd0, 7'd0,
                                 7'd1));
    send_pixel(16'hFFFF, 8'd3, 9'd4);
    send_pixel(16'h0000, 8'd5, 9'd6);
    wait_idle();
    // An undefined color tints toward black; a percent above hundred acts as hundred.
    write_settings(make_settings(7'(TINT_UNDEFINED), 7'd127, 7'd0, 7'd2, 7'd0, 7'd0, 7'd1));
    send_pixel(16'hFFFF, 8'd7, 9'd8);
    send_pixel(16'h5A3C, 8'd9, 9'd10);
    wait_idle();
  endtask

  task automatic test_dot_matrix();
    // A zero grid acts as one, so every pixel sits on a dot.
    write_settings(make_settings(7'(rrpe_pkg::TINT_NONE), 7'd0, 7'd1, 7'd0, 7'd0, 7'd0,
                                 7'd0));
    send_pixel(16'hFFFF, 8'd17, 9'd33);
    send_pixel(16'hFFFF, 8'd255, 9'd511);
    wait_idle();
    write_settings(make_settings(7'(rrpe_pkg::TINT_NONE), 7'd0, 7'd1, 7'd32, 7'd0, 7'd0,
                                 7'd1));
    send_pixel(16'hFFFF, 8'd171, 9'd0);
    send_pixel(16'hFFFF, 8'd139, 9'd32);
    send_pixel(16'hFFFF, 8'd140, 9'd32);
    wait_idle();
    // Rows beyond the panel give a negative logical column that is still on the grid.
    write_settings(make_settings(7'(rrpe_pkg::TINT_NONE), 7'd0, 7'd1, 7'd32, 7'd0, 7'd0,
                                 7'd0));
    send_pixel(16'hFFFF, 8'd32, 9'd511);
    send_pixel(16'hFFFF, 8'd0,  9'd319);
    wait_idle();
  endtask

  task automatic test_scanlines();
    write_settings(make_settings(7'(rrpe_pkg::TINT_NONE), 7'd0, 7'd0, 7'd2, 7'd1, 7'd100,
                                 7'd1));
    send_pixel(16'hFFFF, 8'd1, 9'd50);
    send_pixel(16'hFFFF, 8'd2, 9'd50);
    wait_idle();
    write_settings(make_settings(7'(rrpe_pkg::TINT_MAGENTA), 7'd100, 7'd1, 7'd3, 7'd1,
                                 7'd127, 7'd0));
    send_pixel(16'hFFFF, 8'd0, 9'd1);
    send_pixel(16'hE7BD, 8'd1, 9'd300);
    wait_idle();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 14; phase++) begin
      // The first phase runs without any idling on either side.
      in_gaps  = (phase != 0);
      out_gaps = (phase != 0);
      if (phase == 0) begin
        write_settings(make_settings(7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F));
      end else if (phase == 1) begin
        write_settings(make_settings(7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00));
      end else begin
        write_settings(random_settings());
      end
      repeat (100) send_random_pixel();
      wait_idle();
    end
  endtask

  // The output holds off long enough for the pipeline to fill and stall the input.
  task automatic test_output_stall();
    write_settings(random_settings());
    in_gaps    = 1'b0;
    stall_left = 300;
    repeat (60) send_random_pixel();
    wait_idle();
    in_gaps = 1'b1;
    repeat (20) send_random_pixel();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      pix_out_bus.ready <= 1'b0;
    end else begin
      pix_out_bus.ready <= !(out_gaps && $urandom_range(99) < 31);
    end
  end

  always @(posedge clk) begin
    pixel_expect_t e;
    if (rst_n && pix_out_bus.valid && pix_out_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 100)
          $display("%0t: unexpected pixel_out transfer: expected none, actual %h",
                   $time, pix_out_bus.pixel_out);
      end else begin
        e = pending_pixels.pop_front();
        if (pix_out_bus.pixel_out !== e.want) begin
          mismatch_count++;
          if (mismatch_count <= 100)
            $display("%0t: pixel_out for %h at (%0d,%0d): expected %h, actual %h",
                     $time, e.px, e.x, e.y, e.want, pix_out_bus.pixel_out);
        end
      end
    end
  end

  initial begin
    pix_in_bus.valid    = 1'b0;
    pix_in_bus.pixel_in = '0;
    pix_in_bus.native_x = '0;
    pix_in_bus.native_y = '0;
    pix_out_bus.ready   = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = rrpe_pkg::REG_TINT_COLOR;
    cfg_bus.data        = '0;
    cur_tint_color      = rrpe_pkg::TINT_NONE;
    cur_tint_pct        = '0;
    cur_dot_en          = 1'b0;
    cur_grid            = 6'd2;
    cur_scan_en         = 1'b0;
    cur_scan_pct        = '0;
    cur_rot             = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    test_tint();
    test_dot_matrix();
    test_scanlines();
    test_random_settings();
    test_output_stall();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
